[sv/lphs_pkg.sv]
// Shared types, constants and codes for the linear probing hash set.
package lphs_pkg;

  // Table geometry.
  localparam int TABLE_SIZE = 1024;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 10;

  // Number of probes in a full scan of slots 2 to TABLE_SIZE-1.
  localparam int PROBES     = TABLE_SIZE - 2;

  // Request action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] RES_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] RES_FOUND     = 3'd1;
  localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] RES_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] RES_ZERO_KEY  = 3'd4;

  typedef struct packed {
    logic             action;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
  } res_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic advance;
    logic set_hit;
    logic set_miss;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic in_key_zero;
    logic hit;
    logic last_probe;
    logic out_free;
  } sts_t;

endpackage

[sv/linear_probe_hash_set.sv]
// Top level of the linear probing hash set: controller, datapath and ports.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   req_t  {action, key}
//   out_     output     out_valid / out_ready res_t  {status, slot}
//
// Between acceptance and the next acceptance a request makes p probes, where
// p is the number of probes (1 to TABLE_SIZE-2); each probe is one read and one
// compare on the single read port of the slot store. A zero key makes no probe.
// After reset a clearing pass writes all TABLE_SIZE slots, one per cycle, while
// in_ready stays low.
// A result waits in the output register; a new request is accepted meanwhile
// and only its own hand-off stalls until out_ready frees the register.
module linear_probe_hash_set import lphs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  cmd_t cmd;
  sts_t sts;

  lphs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lphs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[sv/lphs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lphs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/lphs_ctrl.sv]
// Controller state machine that sequences clearing, probing and result hand-off.
module lphs_ctrl import lphs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = sts.in_key_zero ? S_FIN : S_READ;
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.hit || sts.last_probe) state_nxt = S_FIN;
        else state_nxt = S_READ;
      end
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_READ: begin
        cmd = '0;
      end
      S_CMP: begin
        cmd.set_hit  = sts.hit;
        cmd.set_miss = !sts.hit && sts.last_probe;
        cmd.advance  = !sts.hit && !sts.last_probe;
      end
      S_FIN: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

[sv/lphs_dp.sv]
// Datapath: request registers, probe index, slot store and result register.
module lphs_dp import lphs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  req_t in_data,
  input  cmd_t cmd,
  output sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic             act_r;
  logic [KEY_W-1:0] key_r;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [SLOT_W-1:0] cnt_r;
  logic [SLOT_W-1:0] clr_r;
  res_t              res_r;
  res_t              out_data_r;
  logic              out_valid_r;

  logic [SLOT_W-1:0] home;
  logic [KEY_W-1:0]  want;
  logic [KEY_W-1:0]  rdata;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [KEY_W-1:0]  ram_wdata;

  // Home slot of the incoming key; slots 0 and 1 are reserved.
  always_comb begin
    home = in_data.key[SLOT_W-1:0];
    if (home < SLOT_W'(2)) home = home + SLOT_W'(2);
  end

  // Next probe position wraps from the top slot back to slot 2.
  assign idx_nxt = (idx_r == SLOT_W'(TABLE_SIZE - 1)) ? SLOT_W'(2) : idx_r + SLOT_W'(1);

  // An insert looks for an empty slot, a search for the key itself.
  assign want = (act_r == ACT_INSERT) ? '0 : key_r;

  // Status to the controller.
  assign sts.clr_last    = (clr_r == SLOT_W'(TABLE_SIZE - 1));
  assign sts.in_key_zero = (in_data.key == '0);
  assign sts.hit         = (rdata == want);
  assign sts.last_probe  = (cnt_r == SLOT_W'(PROBES - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

  // Clearing sweep counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + SLOT_W'(1);
    end
  end

  // Request capture and probe stepping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
      key_r <= in_data.key;
      idx_r <= home;
      cnt_r <= '0;
      res_r <= '{status: RES_ZERO_KEY, slot: '0};
    end else if (cmd.advance) begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_r + SLOT_W'(1);
    end else if (cmd.set_hit) begin
      res_r.status <= (act_r == ACT_INSERT) ? RES_INSERTED : RES_FOUND;
      res_r.slot   <= OUT_SLOT_W'(idx_r);
    end else if (cmd.set_miss) begin
      res_r.status <= (act_r == ACT_INSERT) ? RES_FULL : RES_NOT_FOUND;
      res_r.slot   <= '0;
    end
  end

  // Slot store writes: zeros during the clearing sweep, the key on an insert hit.
  assign ram_we    = cmd.clr_step || (cmd.set_hit && (act_r == ACT_INSERT));
  assign ram_waddr = cmd.clr_step ? clr_r : idx_r;
  assign ram_wdata = cmd.clr_step ? '0 : key_r;

  lphs_ram #(
    .W(KEY_W),
    .D(TABLE_SIZE)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[bench/tb.sv]
// Self-checking testbench for the linear probing hash set.
module tb;
  import lphs_pkg::*;

  // Cycles without any accepted request or result before the run is declared hung.
  localparam int STALL_LIMIT = 20000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_data   = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  res_t out_data;

  // Predicted contents of the slot store and the count of successful inserts.
  logic [KEY_W-1:0] slot_model [TABLE_SIZE] = '{default: '0};
  logic [10:0]      filled_count = '0;

  // Keys inserted so far, used to aim searches at hits.
  logic [KEY_W-1:0] stored_keys [$];

  // Results predicted for accepted requests, oldest first.
  res_t due_results [$];

  int   error_count   = 0;
  int   quiet_cycles  = 0;
  int   stall_left    = 0;
  int   hold_request  = 0;
  logic gaps_on       = 1'b1;

  linear_probe_hash_set DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // First slot in probe order holding want, or -1 when no slot does.
  function automatic int find_slot(input logic [KEY_W-1:0] key, input logic [KEY_W-1:0] want);
    int home;
    home = int'(key % TABLE_SIZE);
    if (home < 2) home += 2;
    for (int i = home; i < TABLE_SIZE; i++)
      if (slot_model[i] == want) return i;
    for (int i = 2; i < home && i < TABLE_SIZE; i++)
      if (slot_model[i] == want) return i;
    return -1;
  endfunction

  // Applies one request to the predicted store and returns its result.
  function automatic res_t apply_request(input req_t req);
    res_t res;
    int   s;
    res.status = RES_ZERO_KEY;
    res.slot   = '0;
    if (req.key == '0) begin
      res.status = RES_ZERO_KEY;
    end else if (req.action == ACT_INSERT) begin
      s = find_slot(req.key, '0);
      if (s < 0) begin
        res.status = RES_FULL;
      end else begin
        slot_model[s] = req.key;
        filled_count  = filled_count + 1'b1;
        stored_keys.push_back(req.key);
        res.status = RES_INSERTED;
        res.slot   = s[OUT_SLOT_W-1:0];
      end
    end else begin
      s = find_slot(req.key, req.key);
      if (s < 0) begin
        res.status = RES_NOT_FOUND;
      end else begin
        res.status = RES_FOUND;
        res.slot   = s[OUT_SLOT_W-1:0];
      end
    end
    return res;
  endfunction

  // Offers one request and records its predicted result once it is accepted.
  // Valid stays high afterwards so that back-to-back requests need no second drive.
  task automatic send_request(input logic act, input logic [KEY_W-1:0] key);
    int   gap;
    req_t req;
    gap        = pick_gap();
    req.action = act;
    req.key    = key;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    due_results.push_back(apply_request(req));
  endtask

  // Lowers valid and waits until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_stored_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // Result side: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end else if (stall_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_result
    res_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result with no request outstanding: status %0d, slot %0d",
               out_data.status, out_data.slot);
        error_count++;
      end else begin
        want = due_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
          error_count++;
        end
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // A zero key is rejected by both actions.
  task automatic test_zero_key();
    send_request(ACT_INSERT, '0);
    send_request(ACT_SEARCH, '0);
    drain_results();
  endtask

  // Probe order: raised homes, wrap-around from the last slot, duplicates and misses.
  task automatic test_probe_order();
    send_request(ACT_SEARCH, KEY_W'(5));
    send_request(ACT_INSERT, '1);
    send_request(ACT_INSERT, KEY_W'(1023));
    send_request(ACT_INSERT, KEY_W'(1024));
    send_request(ACT_INSERT, KEY_W'(1025));
    send_request(ACT_INSERT, KEY_W'(2));
    send_request(ACT_INSERT, '1);
    send_request(ACT_INSERT, KEY_W'(32'h4000_0000));
    send_request(ACT_INSERT, KEY_W'(32'h5555_5555));
    send_request(ACT_INSERT, KEY_W'(32'h2AAA_AAAA));
    send_request(ACT_SEARCH, '1);
    send_request(ACT_SEARCH, KEY_W'(1023));
    send_request(ACT_SEARCH, KEY_W'(1024));
    send_request(ACT_SEARCH, KEY_W'(1025));
    send_request(ACT_SEARCH, KEY_W'(2));
    send_request(ACT_SEARCH, KEY_W'(32'h4000_0000));
    send_request(ACT_SEARCH, KEY_W'(32'h5555_5555));
    send_request(ACT_SEARCH, KEY_W'(32'h2AAA_AAAA));
    send_request(ACT_SEARCH, KEY_W'(2047));
    drain_results();
  endtask

  // Mixed traffic at moderate load; misses are kept rare since each one scans the table.
  task automatic test_random_mix();
    logic [KEY_W-1:0] key;
    int               r;
    for (int n = 0; n < 750; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      r   = $urandom_range(0, 99);
      key = KEY_W'($urandom());
      if (r < 2) begin
        send_request(1'($urandom_range(0, 1)), '0);
      end else if (r < 32) begin
        case ($urandom_range(0, 9))
          0: key = pick_stored_key();
          1: key[SLOT_W-1:0] = SLOT_W'($urandom_range(0, 1));
          2: key[SLOT_W-1:0] = '1;
          default: ;
        endcase
        send_request(ACT_INSERT, key);
      end else if (r < 94) begin
        send_request(ACT_SEARCH, pick_stored_key());
      end else begin
        send_request(ACT_SEARCH, key);
      end
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  // The result side holds off while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    @(negedge clk);
    hold_request = 300;
    @(posedge clk);
    repeat (16) begin
      if ($urandom_range(0, 1))
        send_request(ACT_SEARCH, pick_stored_key());
      else
        send_request(ACT_INSERT, KEY_W'($urandom()));
    end
    drain_results();
    gaps_on = 1'b1;
  endtask

  // Fills every remaining slot with a key whose home is that slot.
  task automatic test_fill_table();
    logic [KEY_W-1:0] key;
    for (int s = 2; s < TABLE_SIZE; s++) begin
      if (slot_model[s] == '0) begin
        key = KEY_W'($urandom());
        key[SLOT_W-1:0] = SLOT_W'(s);
        send_request(ACT_INSERT, key);
      end
    end
    drain_results();
  endtask

  // A full table refuses inserts while searches still work.
  task automatic test_full_table();
    send_request(ACT_INSERT, KEY_W'($urandom()));
    send_request(ACT_INSERT, KEY_W'(1));
    send_request(ACT_INSERT, '1);
    send_request(ACT_SEARCH, pick_stored_key());
    send_request(ACT_SEARCH, slot_model[TABLE_SIZE-1]);
    send_request(ACT_SEARCH, KEY_W'($urandom()));
    send_request(ACT_SEARCH, '0);
    drain_results();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_key();
    test_probe_order();
    test_random_mix();
    test_output_backpressure();
    test_fill_table();
    test_full_table();
    // Allow for a stray result arriving as late as a full scan.
    repeat (2 * PROBES + 8) @(posedge clk);
    if (error_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
